### hdl/one_wire_master_byte_engine_macros.svh
// Assertion macros for the one-wire master byte engine.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ONE_WIRE_MASTER_BYTE_ENGINE_MACROS_SVH
`define ONE_WIRE_MASTER_BYTE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define OWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("owm assertion failed");
`define OWM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("owm assertion failed");
`else
`define OWM_ASSERT(lbl, clk, rst_n, prop)
`define OWM_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### hdl/owm_pkg.sv
// Shared constants and codes for the one-wire master byte engine.
// No dependencies.
`default_nettype none
package owm_pkg;

  localparam int BITS_PER_WORD_DEF = 8;

  localparam int TICK_W  = 16;
  localparam int SHORT_W = 8;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW   = 3'd0,
    CFG_RESET_WAIT  = 3'd1,
    CFG_SLOT_START  = 3'd2,
    CFG_WRITE_HOLD  = 3'd3,
    CFG_WRITE_REC   = 3'd4,
    CFG_READ_SAMPLE = 3'd5,
    CFG_READ_REC    = 3'd6
  } cfg_idx_t;

  localparam logic [TICK_W-1:0]  RESET_LOW_DEF   = 16'd200;
  localparam logic [TICK_W-1:0]  RESET_WAIT_DEF  = 16'd100;
  localparam logic [SHORT_W-1:0] SLOT_START_DEF  = 8'd1;
  localparam logic [TICK_W-1:0]  WRITE_HOLD_DEF  = 16'd30;
  localparam logic [SHORT_W-1:0] WRITE_REC_DEF   = 8'd2;
  localparam logic [SHORT_W-1:0] READ_SAMPLE_DEF = 8'd2;
  localparam logic [TICK_W-1:0]  READ_REC_DEF    = 16'd20;

endpackage
`default_nettype wire

### hdl/owm_ifs.sv
// Handshake channel interfaces: tick/command input, result output, register write.
// Depends on owm_pkg for field widths.
`default_nettype none
interface owm_in_if import owm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] data_byte;
  logic              bus_level;

  modport source (output valid, output req_type, output data_byte, output bus_level,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input bus_level,
                output ready);
endinterface

interface owm_out_if import owm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              line_low;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_data;
  logic              rejected;

  modport source (output valid, output line_low, output busy_res, output done_res,
                  output read_data, output rejected, input ready);
  modport sink (input valid, input line_low, input busy_res, input done_res,
                input read_data, input rejected, output ready);
endinterface

interface owm_cfg_if import owm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/one_wire_master_byte_engine.sv
// A result is registered when its tick transaction is accepted.
// Throughput: one tick transaction per cycle; the slot timer, phase and shift
// register update in a single pass, and a stalled result register holds input off.
// Reset (rst_n low, synchronous): bus released, engine idle, timing registers
// back to their defaults, held read byte cleared.
// Depends on owm_pkg, owm_ifs and one_wire_master_byte_engine_macros.svh.
`default_nettype none
`include "one_wire_master_byte_engine_macros.svh"
module one_wire_master_byte_engine import owm_pkg::*; #(
  parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  owm_in_if.sink     in_ch,
  owm_out_if.source  out_ch,
  owm_cfg_if.sink    cfg_ch
);

  localparam int BI_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
  localparam logic [BI_W-1:0] BI_LAST = BI_W'(BITS_PER_WORD - 1);
  localparam logic [BITS_PER_WORD-1:0] MSB_ONE =
    BITS_PER_WORD'(1) << (BITS_PER_WORD - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_SLOT_START,
    PH_WR_HOLD, PH_WR_REC, PH_RD_WAIT, PH_RD_REC
  } phase_t;

  logic [TICK_W-1:0]  reset_low_r, reset_wait_r, write_hold_r, read_rec_r;
  logic [SHORT_W-1:0] slot_start_r, write_rec_r, read_sample_r;

  phase_t                 phase_r, phase_nxt;
  logic [BI_W-1:0]        bit_index_r, bit_index_nxt;
  logic [TICK_W-1:0]      tick_count_r, tick_count_nxt;
  logic [BITS_PER_WORD-1:0] shift_r, shift_nxt;
  logic [BITS_PER_WORD-1:0] last_read_r, last_read_nxt;
  logic                   drive_low_r, drive_low_nxt;
  logic                   op_read_r, op_read_nxt;

  logic              out_valid_r;
  logic              line_low_r, busy_r, done_r, rejected_r;
  logic              line_nxt, done_nxt, rej_nxt, enter;
  logic [TICK_W-1:0] len;
  logic [TICK_W:0]   tick_inc;
  logic              in_take;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_index_nxt  = bit_index_r;
    tick_count_nxt = tick_count_r;
    shift_nxt      = shift_r;
    last_read_nxt  = last_read_r;
    drive_low_nxt  = drive_low_r;
    op_read_nxt    = op_read_r;
    line_nxt       = 1'b0;
    done_nxt       = 1'b0;
    rej_nxt        = 1'b0;
    enter          = 1'b0;
    len            = '0;
    tick_inc       = '0;

    if (req_t'(in_ch.req_type) != REQ_TICK) begin
      if (phase_r == PH_IDLE) begin
        bit_index_nxt  = '0;
        tick_count_nxt = '0;
        drive_low_nxt  = 1'b1;
        case (req_t'(in_ch.req_type))
          REQ_RESET: phase_nxt = PH_RST_LOW;
          REQ_WRITE: begin
            op_read_nxt = 1'b0;
            shift_nxt   = BITS_PER_WORD'(in_ch.data_byte);
            phase_nxt   = PH_SLOT_START;
          end
          default: begin
            op_read_nxt = 1'b1;
            shift_nxt   = '0;
            phase_nxt   = PH_SLOT_START;
          end
        endcase
      end else begin
        rej_nxt = 1'b1;
      end
    end

    case (phase_nxt)
      PH_RST_LOW:    len = reset_low_r;
      PH_RST_WAIT:   len = reset_wait_r;
      PH_SLOT_START: len = TICK_W'(slot_start_r);
      PH_WR_HOLD:    len = write_hold_r;
      PH_WR_REC:     len = TICK_W'(write_rec_r);
      PH_RD_WAIT:    len = TICK_W'(read_sample_r);
      PH_RD_REC:     len = read_rec_r;
      default:       len = TICK_W'(1);
    endcase
    if (len == '0) begin
      len = TICK_W'(1);
    end

    if (phase_nxt != PH_IDLE) begin
      line_nxt       = drive_low_nxt;
      tick_inc       = {1'b0, tick_count_nxt} + 1'b1;
      tick_count_nxt = tick_inc[TICK_W-1:0];
      if (tick_inc >= {1'b0, len}) begin
        enter = 1'b1;
        case (phase_nxt)
          PH_RST_LOW:    phase_nxt = PH_RST_WAIT;
          PH_SLOT_START: phase_nxt = op_read_nxt ? PH_RD_WAIT : PH_WR_HOLD;
          PH_WR_HOLD:    phase_nxt = PH_WR_REC;
          PH_WR_REC: begin
            shift_nxt = shift_nxt >> 1;
            if (bit_index_nxt == BI_LAST) begin
              bit_index_nxt = '0;
              phase_nxt     = PH_IDLE;
              done_nxt      = 1'b1;
            end else begin
              bit_index_nxt = bit_index_nxt + 1'b1;
              phase_nxt     = PH_SLOT_START;
            end
          end
          PH_RD_WAIT: begin
            shift_nxt = (shift_nxt >> 1) | (in_ch.bus_level ? MSB_ONE : '0);
            phase_nxt = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (bit_index_nxt == BI_LAST) begin
              bit_index_nxt = '0;
              last_read_nxt = shift_nxt;
              phase_nxt     = PH_IDLE;
              done_nxt      = 1'b1;
            end else begin
              bit_index_nxt = bit_index_nxt + 1'b1;
              phase_nxt     = PH_SLOT_START;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
        endcase
      end
    end

    if (enter) begin
      tick_count_nxt = '0;
      drive_low_nxt  = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_START) ||
                       ((phase_nxt == PH_WR_HOLD) && !shift_nxt[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_index_r  <= '0;
      tick_count_r <= '0;
      shift_r      <= '0;
      last_read_r  <= '0;
      drive_low_r  <= 1'b0;
      op_read_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        phase_r      <= phase_nxt;
        bit_index_r  <= bit_index_nxt;
        tick_count_r <= tick_count_nxt;
        shift_r      <= shift_nxt;
        last_read_r  <= last_read_nxt;
        drive_low_r  <= drive_low_nxt;
        op_read_r    <= op_read_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      line_low_r <= line_nxt;
      busy_r     <= (phase_nxt != PH_IDLE);
      done_r     <= done_nxt;
      rejected_r <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r   <= RESET_LOW_DEF;
      reset_wait_r  <= RESET_WAIT_DEF;
      slot_start_r  <= SLOT_START_DEF;
      write_hold_r  <= WRITE_HOLD_DEF;
      write_rec_r   <= WRITE_REC_DEF;
      read_sample_r <= READ_SAMPLE_DEF;
      read_rec_r    <= READ_REC_DEF;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_RESET_LOW:   reset_low_r   <= cfg_ch.data;
        CFG_RESET_WAIT:  reset_wait_r  <= cfg_ch.data;
        CFG_SLOT_START:  slot_start_r  <= cfg_ch.data[SHORT_W-1:0];
        CFG_WRITE_HOLD:  write_hold_r  <= cfg_ch.data;
        CFG_WRITE_REC:   write_rec_r   <= cfg_ch.data[SHORT_W-1:0];
        CFG_READ_SAMPLE: read_sample_r <= cfg_ch.data[SHORT_W-1:0];
        CFG_READ_REC:    read_rec_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.line_low  = line_low_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.read_data = BYTE_W'(last_read_r);
  assign out_ch.rejected  = rejected_r;

  `OWM_ASSERT(a_idle_released, clk, rst_n, (phase_r != PH_IDLE) || !drive_low_r)
  `OWM_ASSERT(a_idle_timer_clear, clk, rst_n, (phase_r != PH_IDLE) || (tick_count_r == '0))
  `OWM_ASSERT(a_done_not_busy, clk, rst_n, !(out_valid_r && done_r && busy_r))
  `OWM_ASSERT_NEXT(a_busy_tracks_phase, clk, rst_n, in_take,
                   busy_r == (phase_r != PH_IDLE))

endmodule
`default_nettype wire
